// ===== hw/rtl/btt_pkg.sv =====
// Shared types and constants of the bucketed transposition table.
// Holds the request, response and table entry layouts and the request codes.
// No dependencies.
`default_nettype none

package btt_pkg;

  // Default sizes of the table.
  localparam int unsigned NUM_BUCKETS_DEF = 1024;
  localparam int unsigned BUCKET_WAYS_DEF = 4;
  localparam int unsigned AGE_SLOTS_DEF   = 16;

  // Field widths fixed by the request and entry formats.
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned LOCK_W  = 32;
  localparam int unsigned MOVE_W  = 32;
  localparam int unsigned DEPTH_W = 8;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned DATE_W  = 4;

  // Configuration port.
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_IDX_LSB = 2;
  localparam logic        REG_CURRENT_DATE = 1'b0;

  // Request kinds.
  localparam logic [2:0] REQ_PROBE       = 3'd0;
  localparam logic [2:0] REQ_STORE_EVAL  = 3'd1;
  localparam logic [2:0] REQ_STORE_LOWER = 3'd2;
  localparam logic [2:0] REQ_STORE_UPPER = 3'd3;
  localparam logic [2:0] REQ_STORE_EXACT = 3'd4;
  localparam logic [2:0] REQ_NO_MOVES    = 3'd5;

  typedef struct packed {
    logic [2:0]                req_type;
    logic [KEY_W-1:0]          key;
    logic [MOVE_W-1:0]         move_code;
    logic [DEPTH_W-1:0]        search_depth;
    logic signed [VALUE_W-1:0] bound_value;
    logic signed [VALUE_W-1:0] static_eval;
    logic                      singular_flag;
    logic                      pv_flag;
  } req_t;

  typedef struct packed {
    logic                      hit;
    logic [MOVE_W-1:0]         out_move;
    logic [DEPTH_W-1:0]        out_upper_depth;
    logic signed [VALUE_W-1:0] out_upper_value;
    logic [DEPTH_W-1:0]        out_lower_depth;
    logic signed [VALUE_W-1:0] out_lower_value;
    logic signed [VALUE_W-1:0] out_eval;
    logic                      out_singular;
    logic                      out_pv;
    logic                      out_no_moves;
  } rsp_t;

  // One way of a bucket.
  typedef struct packed {
    logic [LOCK_W-1:0]         lock;
    logic [MOVE_W-1:0]         move;
    logic [DEPTH_W-1:0]        up_depth;
    logic signed [VALUE_W-1:0] up_value;
    logic [DEPTH_W-1:0]        lo_depth;
    logic signed [VALUE_W-1:0] lo_value;
    logic signed [VALUE_W-1:0] eval;
    logic [DATE_W-1:0]         age;
    logic                      singular;
    logic                      pv;
    logic                      no_moves;
  } entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bucketed_transposition_table_core.sv =====
// Bucketed transposition table with age and depth replacement.
// One bucket row per memory word; read, modify and write back per item.
// Depends on btt_pkg.
`default_nettype none

// Channel   Direction  Handshake                      Payload
// --------  ---------  -----------------------------  ---------------------
// request   in         in_valid_i / in_ready_o        in_data_i  (req_t)
// response  out        out_valid_o / out_ready_i      out_data_o (rsp_t)
// config    in         psel/penable/pwrite, pready=1  paddr, pwdata, prdata
//
// For a power-of-two NUM_BUCKETS an item takes the bucket read, then lock
// compare, victim choice and write-back. Otherwise the bucket index is
// formed first in the steps slice fold, reciprocal quotient estimate,
// remainder and final correction.
// After reset the table is swept to zero, one bucket per cycle; no item is
// accepted during the sweep.
// A new item is accepted while a result still waits in the output register;
// write-back of that next item stalls until the output register is free.

module bucketed_transposition_table_core #(
  parameter int unsigned NUM_BUCKETS = btt_pkg::NUM_BUCKETS_DEF,
  parameter int unsigned BUCKET_WAYS = btt_pkg::BUCKET_WAYS_DEF,
  parameter int unsigned AGE_SLOTS   = btt_pkg::AGE_SLOTS_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  btt_pkg::req_t                     in_data_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output btt_pkg::rsp_t                     out_data_o,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [btt_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire  [btt_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [btt_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import btt_pkg::*;

  localparam int unsigned IdxW   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned WayW   = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;
  localparam int unsigned AgeW   = $clog2(AGE_SLOTS);
  localparam int unsigned ScoreW = AgeW + DEPTH_W + 1;
  localparam bit          IsPow2 = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);
  localparam logic [IdxW-1:0] BucketMask = IdxW'(NUM_BUCKETS - 1);
  localparam logic [IdxW-1:0] LastBucket = IdxW'(NUM_BUCKETS - 1);

  // Remainder unit constants. The folded key is below 2^FoldW, and Recip
  // approximates 2^FoldW / NUM_BUCKETS from below.
  localparam int unsigned     FoldW  = IdxW + 18;
  localparam int unsigned     RecipW = 19;
  localparam longint unsigned BktL   = 64'(NUM_BUCKETS);
  localparam longint unsigned Fold1  = (64'd1 << 16) % BktL;
  localparam longint unsigned Fold2  = (64'd1 << 32) % BktL;
  localparam longint unsigned Fold3  = (64'd1 << 48) % BktL;
  localparam longint unsigned Recip  = (64'd1 << FoldW) / BktL;
  localparam logic [IdxW+1:0] Bkt1   = (IdxW + 2)'(NUM_BUCKETS);
  localparam logic [IdxW+1:0] Bkt2   = (IdxW + 2)'(2 * NUM_BUCKETS);
  localparam logic [IdxW+1:0] Bkt3   = (IdxW + 2)'(3 * NUM_BUCKETS);

  // Remainder unit steps.
  localparam logic [1:0] DivFold = 2'd0;
  localparam logic [1:0] DivQuot = 2'd1;
  localparam logic [1:0] DivRem  = 2'd2;
  localparam logic [1:0] DivLast = 2'd3;

  // Sequencer states.
  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_DIV    = 2'd2;
  localparam logic [1:0] ST_LOOKUP = 2'd3;

  typedef entry_t [BUCKET_WAYS-1:0] row_t;

  // Reduction of a 4-bit date or age modulo AGE_SLOTS; only evaluated on
  // constants to fill a small lookup table.
  function automatic logic [AgeW-1:0] age_mod(input logic [DATE_W-1:0] v);
    logic [8:0] r;
    r = {5'b0, v};
    for (int i = 0; i < 16; i++) begin
      if (r >= 9'(AGE_SLOTS)) begin
        r = r - 9'(AGE_SLOTS);
      end
    end
    return r[AgeW-1:0];
  endfunction

  logic [AgeW-1:0] age_tbl [16];
  for (genvar g = 0; g < 16; g++) begin : g_age_tbl
    assign age_tbl[g] = age_mod(DATE_W'(g));
  end

  logic [1:0]          state_q, state_d;
  logic [IdxW-1:0]     clr_cnt_q;
  logic [DATE_W-1:0]   date_q;
  req_t                req_q;
  logic [IdxW-1:0]     bucket_q;
  logic [1:0]          div_cnt_q;
  logic [IdxW+15:0]    fold_p1, fold_p2, fold_p3;
  logic [FoldW-1:0]    fold_sum;
  logic [FoldW-1:0]    fold_q;
  logic [RecipW+17:0]  qest_prod;
  logic [RecipW-1:0]   qest_q;
  logic [IdxW+RecipW-1:0] qest_mul;
  logic [FoldW-1:0]    rem_wide;
  logic [IdxW+1:0]     rem0_q;
  logic [IdxW+1:0]     rem_fix;
  logic                out_valid_q;
  rsp_t                out_data_q;

  row_t                mem_q [NUM_BUCKETS];
  row_t                rd_row_q;
  logic                mem_re, mem_we;
  logic [IdxW-1:0]     mem_raddr, mem_waddr;
  row_t                mem_wdata;

  logic                in_acc;
  logic                lookup_done;
  logic                kind_ok;
  logic                cfg_wr;

  // Configuration register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    if (paddr[CFG_IDX_LSB] == REG_CURRENT_DATE) begin
      prdata = CFG_DATA_W'(date_q);
    end
  end

  // Key remainder for a bucket count that is not a power of two. The four
  // 16-bit key slices are folded with the constants 2^(16*i) mod NUM_BUCKETS,
  // the quotient of the folded value is estimated by a reciprocal multiply
  // that comes out at most three short, and a compare and subtract against
  // one, two or three bucket counts finishes the remainder.
  assign fold_p1  = (IdxW + 16)'(req_q.key[31:16]) * (IdxW + 16)'(Fold1);
  assign fold_p2  = (IdxW + 16)'(req_q.key[47:32]) * (IdxW + 16)'(Fold2);
  assign fold_p3  = (IdxW + 16)'(req_q.key[63:48]) * (IdxW + 16)'(Fold3);
  assign fold_sum = FoldW'(req_q.key[15:0]) + FoldW'(fold_p1) + FoldW'(fold_p2) +
                    FoldW'(fold_p3);

  assign qest_prod = (RecipW + 18)'(fold_q[FoldW-1:IdxW]) * (RecipW + 18)'(Recip);
  assign qest_mul  = (IdxW + RecipW)'(qest_q) * (IdxW + RecipW)'(NUM_BUCKETS);
  assign rem_wide  = fold_q - qest_mul[FoldW-1:0];

  always_comb begin
    if (rem0_q >= Bkt3) begin
      rem_fix = rem0_q - Bkt3;
    end else if (rem0_q >= Bkt2) begin
      rem_fix = rem0_q - Bkt2;
    end else if (rem0_q >= Bkt1) begin
      rem_fix = rem0_q - Bkt1;
    end else begin
      rem_fix = rem0_q;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // Reads are issued at acceptance for power-of-two tables, else when the
  // remainder is complete.
  always_comb begin
    if (state_q == ST_IDLE) begin
      mem_re    = in_acc && IsPow2;
      mem_raddr = in_data_i.key[IdxW-1:0] & BucketMask;
    end else begin
      mem_re    = (state_q == ST_DIV) && (div_cnt_q == DivLast);
      mem_raddr = rem_fix[IdxW-1:0];
    end
  end

  // Per-way victim scores: ((date - age) mod AGE_SLOTS) * 256 - deeper depth.
  logic [AgeW-1:0]          date_m;
  logic signed [ScoreW-1:0] score [BUCKET_WAYS];

  assign date_m = age_tbl[date_q];

  always_comb begin
    for (int w = 0; w < BUCKET_WAYS; w++) begin
      logic [AgeW-1:0]    age_m;
      logic [AgeW-1:0]    diff;
      logic [DEPTH_W-1:0] deep;
      age_m = age_tbl[rd_row_q[w].age];
      if (date_m >= age_m) begin
        diff = date_m - age_m;
      end else begin
        diff = AgeW'((AgeW + 1)'(date_m) + (AgeW + 1)'(AGE_SLOTS) - (AgeW + 1)'(age_m));
      end
      deep = (rd_row_q[w].up_depth > rd_row_q[w].lo_depth) ?
             rd_row_q[w].up_depth : rd_row_q[w].lo_depth;
      score[w] = $signed({1'b0, diff, {DEPTH_W{1'b0}}}) -
                 $signed({{(AgeW + 1){1'b0}}, deep});
    end
  end

  // First way with a matching lock, and first way of highest score.
  logic                     hit_found;
  logic [WayW-1:0]          hit_idx;
  logic [WayW-1:0]          vic_idx;
  logic signed [ScoreW-1:0] best_sc;

  always_comb begin
    hit_found = 1'b0;
    hit_idx   = '0;
    vic_idx   = '0;
    best_sc   = score[0];
    for (int w = 0; w < BUCKET_WAYS; w++) begin
      if (!hit_found && (rd_row_q[w].lock == req_q.key[KEY_W-1:KEY_W-LOCK_W])) begin
        hit_found = 1'b1;
        hit_idx   = WayW'(w);
      end
      if (score[w] > best_sc) begin
        best_sc = score[w];
        vic_idx = WayW'(w);
      end
    end
  end

  assign kind_ok = (req_q.req_type <= REQ_NO_MOVES);

  // Row update.
  row_t   new_row;
  entry_t upd;
  entry_t fresh;

  always_comb begin
    new_row = rd_row_q;

    // Replacement entry: keeps only the victim's eval; a store that misses takes the request's static eval instead.
    fresh          = '0;
    fresh.lock     = req_q.key[KEY_W-1:KEY_W-LOCK_W];
    fresh.age      = date_q;
    fresh.eval     = rd_row_q[vic_idx].eval;

    upd     = rd_row_q[hit_idx];
    upd.age = date_q;

    if (req_q.req_type == REQ_NO_MOVES) begin
      fresh.no_moves   = 1'b1;
      new_row[vic_idx] = fresh;
    end else if (hit_found) begin
      case (req_q.req_type)
        REQ_STORE_EVAL: begin
          upd.eval = req_q.static_eval;
        end
        REQ_STORE_LOWER: begin
          upd.move     = req_q.move_code;
          upd.lo_depth = req_q.search_depth;
          upd.lo_value = req_q.bound_value;
          upd.eval     = req_q.static_eval;
          upd.singular = req_q.singular_flag;
          upd.pv       = req_q.pv_flag;
        end
        REQ_STORE_UPPER: begin
          upd.up_depth = req_q.search_depth;
          upd.up_value = req_q.bound_value;
          upd.eval     = req_q.static_eval;
          upd.pv       = upd.pv | req_q.pv_flag;
        end
        REQ_STORE_EXACT: begin
          upd.move     = req_q.move_code;
          upd.up_depth = req_q.search_depth;
          upd.up_value = req_q.bound_value;
          upd.lo_depth = req_q.search_depth;
          upd.lo_value = req_q.bound_value;
          upd.eval     = req_q.static_eval;
          upd.singular = req_q.singular_flag;
          upd.pv       = req_q.pv_flag;
          upd.no_moves = 1'b0;
        end
        default: begin
        end
      endcase
      new_row[hit_idx] = upd;
    end else if (req_q.req_type != REQ_PROBE) begin
      fresh.eval = req_q.static_eval;
      case (req_q.req_type)
        REQ_STORE_LOWER: begin
          fresh.move     = req_q.move_code;
          fresh.lo_depth = req_q.search_depth;
          fresh.lo_value = req_q.bound_value;
          fresh.singular = req_q.singular_flag;
          fresh.pv       = req_q.pv_flag;
        end
        REQ_STORE_UPPER: begin
          fresh.up_depth = req_q.search_depth;
          fresh.up_value = req_q.bound_value;
        end
        REQ_STORE_EXACT: begin
          fresh.move     = req_q.move_code;
          fresh.up_depth = req_q.search_depth;
          fresh.up_value = req_q.bound_value;
          fresh.lo_depth = req_q.search_depth;
          fresh.lo_value = req_q.bound_value;
          fresh.singular = req_q.singular_flag;
          fresh.pv       = req_q.pv_flag;
        end
        default: begin
        end
      endcase
      new_row[vic_idx] = fresh;
    end
  end

  // Response: the matching way as it stands after the update.
  rsp_t   rsp;
  entry_t res_ent;

  always_comb begin
    res_ent = new_row[hit_idx];
    rsp     = '0;
    if (hit_found && kind_ok) begin
      rsp.hit             = 1'b1;
      rsp.out_move        = res_ent.move;
      rsp.out_upper_depth = res_ent.up_depth;
      rsp.out_upper_value = res_ent.up_value;
      rsp.out_lower_depth = res_ent.lo_depth;
      rsp.out_lower_value = res_ent.lo_value;
      rsp.out_eval        = res_ent.eval;
      rsp.out_singular    = res_ent.singular;
      rsp.out_pv          = res_ent.pv;
      rsp.out_no_moves    = res_ent.no_moves;
    end
  end

  assign lookup_done = (state_q == ST_LOOKUP) && (!out_valid_q || out_ready_i);

  // Write port: the reset sweep, then write-back of the modified row.
  always_comb begin
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = '0;
    end else begin
      mem_we    = lookup_done && kind_ok;
      mem_waddr = bucket_q;
      mem_wdata = new_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_row_q <= mem_q[mem_raddr];
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == LastBucket) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_d = IsPow2 ? ST_LOOKUP : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_cnt_q == DivLast) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (lookup_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      date_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cfg_wr && (paddr[CFG_IDX_LSB] == REG_CURRENT_DATE)) begin
        date_q <= pwdata[DATE_W-1:0];
      end
      if (lookup_done) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q     <= in_data_i;
      div_cnt_q <= DivFold;
    end else if (state_q == ST_DIV) begin
      div_cnt_q <= div_cnt_q + 2'd1;
    end
    if (state_q == ST_DIV) begin
      case (div_cnt_q)
        DivFold: begin
          fold_q <= fold_sum;
        end
        DivQuot: begin
          qest_q <= qest_prod[RecipW+17:18];
        end
        DivRem: begin
          rem0_q <= rem_wide[IdxW+1:0];
        end
        default: begin
        end
      endcase
    end
    if (mem_re) begin
      bucket_q <= mem_raddr;
    end
    if (lookup_done) begin
      out_data_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // No table write while waiting for an item.
  a_no_write_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !mem_we)
    else $error("table written while idle");

  // A stalled write-back keeps the bucket row it read.
  a_row_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOKUP) && !lookup_done |=> $stable(rd_row_q))
    else $error("bucket row changed during stall");

  // A new result only comes from a completed lookup.
  a_result_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_LOOKUP)
    else $error("result without lookup");

  // Unused request codes never touch the table.
  a_bad_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    lookup_done && (req_q.req_type > REQ_NO_MOVES) |-> !mem_we)
    else $error("unused request code wrote the table");

endmodule

`default_nettype wire
